>>> hw/rtl/tcc_pkg.sv
// -----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the circumcircle point test.
// -----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // quotient bits produced by the divider chain, one per cell
  localparam int QUOT_BITS = 32;

  localparam logic [QUOT_BITS-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [QUOT_BITS-1:0] NEG_LIMIT = 32'h8000_0000;

  // per-beat flags travelling alongside the datapath
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic clip_x;
    logic clip_y;
    logic in_circle;
    logic corner;
    logic degen;
  } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcc_front.sv
// -----------------------------------------------------------------------------
// tcc_front
// Four-stage arithmetic front end: differences, products, numerators and
// incircle determinant, then magnitudes and signs for the divider chain.
// -----------------------------------------------------------------------------
`default_nettype none

module tcc_front import tcc_pkg::*; #(
  parameter int COORD_BITS = 16,
  localparam int NB = 3*COORD_BITS + 3,
  localparam int DB = 2*COORD_BITS + 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         out_valid,
  output logic [NB-1:0]                mag_x,
  output logic [NB-1:0]                mag_y,
  output logic [DB-1:0]                den,
  output side_t                        side
);

  localparam int W    = COORD_BITS;
  localparam int DW   = W + 1;
  localparam int ABW  = 2*W + 1;
  localparam int DDW  = 2*W + 3;
  localparam int LW   = 2*W + 3;
  localparam int CW   = 2*W + 3;
  localparam int NXW  = 3*W + 4;
  localparam int DETW = 4*W + 6;

  // stage 1
  logic                 s1_valid;
  logic                 s1_corner;
  logic signed [W-1:0]  s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;
  logic signed [DW-1:0] s1_dcyby, s1_dayc, s1_dbyay, s1_dcxbx, s1_daxc, s1_dbxax;
  logic signed [DW-1:0] s1_adx, s1_ady, s1_bdx, s1_bdy, s1_cdx, s1_cdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_ax <= a_x;
    s1_ay <= a_y;
    s1_bx <= b_x;
    s1_by <= b_y;
    s1_cx <= c_x;
    s1_cy <= c_y;
    s1_corner <= (query_x == a_x && query_y == a_y) ||
                 (query_x == b_x && query_y == b_y) ||
                 (query_x == c_x && query_y == c_y);
    s1_dcyby <= DW'(c_y) - DW'(b_y);
    s1_dayc  <= DW'(a_y) - DW'(c_y);
    s1_dbyay <= DW'(b_y) - DW'(a_y);
    s1_dcxbx <= DW'(c_x) - DW'(b_x);
    s1_daxc  <= DW'(a_x) - DW'(c_x);
    s1_dbxax <= DW'(b_x) - DW'(a_x);
    s1_adx   <= DW'(a_x) - DW'(query_x);
    s1_ady   <= DW'(a_y) - DW'(query_y);
    s1_bdx   <= DW'(b_x) - DW'(query_x);
    s1_bdy   <= DW'(b_y) - DW'(query_y);
    s1_cdx   <= DW'(c_x) - DW'(query_x);
    s1_cdy   <= DW'(c_y) - DW'(query_y);
  end

  // stage 2
  logic                  s2_valid;
  logic                  s2_corner;
  logic signed [ABW-1:0] s2_ab, s2_cd, s2_ef;
  logic signed [DDW-1:0] s2_dd;
  logic signed [LW-1:0]  s2_la, s2_lb, s2_lc;
  logic signed [CW-1:0]  s2_ca, s2_cb, s2_cc;
  logic signed [DW-1:0]  s2_dcyby, s2_dayc, s2_dbyay, s2_dcxbx, s2_daxc, s2_dbxax;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_corner <= s1_corner;
    s2_ab <= ABW'(s1_ax) * ABW'(s1_ax) + ABW'(s1_ay) * ABW'(s1_ay);
    s2_cd <= ABW'(s1_bx) * ABW'(s1_bx) + ABW'(s1_by) * ABW'(s1_by);
    s2_ef <= ABW'(s1_cx) * ABW'(s1_cx) + ABW'(s1_cy) * ABW'(s1_cy);
    s2_dd <= DDW'(s1_ax) * DDW'(s1_dcyby) + DDW'(s1_bx) * DDW'(s1_dayc) +
             DDW'(s1_cx) * DDW'(s1_dbyay);
    s2_la <= LW'(s1_adx) * LW'(s1_adx) + LW'(s1_ady) * LW'(s1_ady);
    s2_lb <= LW'(s1_bdx) * LW'(s1_bdx) + LW'(s1_bdy) * LW'(s1_bdy);
    s2_lc <= LW'(s1_cdx) * LW'(s1_cdx) + LW'(s1_cdy) * LW'(s1_cdy);
    s2_ca <= CW'(s1_bdx) * CW'(s1_cdy) - CW'(s1_bdy) * CW'(s1_cdx);
    s2_cb <= CW'(s1_adx) * CW'(s1_cdy) - CW'(s1_ady) * CW'(s1_cdx);
    s2_cc <= CW'(s1_adx) * CW'(s1_bdy) - CW'(s1_ady) * CW'(s1_bdx);
    s2_dcyby <= s1_dcyby;
    s2_dayc  <= s1_dayc;
    s2_dbyay <= s1_dbyay;
    s2_dcxbx <= s1_dcxbx;
    s2_daxc  <= s1_daxc;
    s2_dbxax <= s1_dbxax;
  end

  // stage 3
  logic                   s3_valid;
  logic                   s3_corner;
  logic signed [NXW-1:0]  s3_nx, s3_ny;
  logic signed [DETW-1:0] s3_det;
  logic signed [DDW-1:0]  s3_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_corner <= s2_corner;
    s3_dd     <= s2_dd;
    s3_nx <= NXW'(s2_ab) * NXW'(s2_dcyby) + NXW'(s2_cd) * NXW'(s2_dayc) +
             NXW'(s2_ef) * NXW'(s2_dbyay);
    s3_ny <= NXW'(s2_ab) * NXW'(s2_dcxbx) + NXW'(s2_cd) * NXW'(s2_daxc) +
             NXW'(s2_ef) * NXW'(s2_dbxax);
    s3_det <= DETW'(s2_la) * DETW'(s2_ca) - DETW'(s2_lb) * DETW'(s2_cb) +
              DETW'(s2_lc) * DETW'(s2_cc);
  end

  // stage 4: magnitudes and signs
  logic signed [NXW-1:0] abs_nx, abs_ny;
  logic signed [DDW-1:0] abs_dd;

  always_comb begin
    abs_nx = s3_nx[NXW-1] ? -s3_nx : s3_nx;
    abs_ny = s3_ny[NXW-1] ? -s3_ny : s3_ny;
    abs_dd = s3_dd[DDW-1] ? -s3_dd : s3_dd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_valid;
    end
    mag_x <= abs_nx[NB-1:0];
    mag_y <= abs_ny[NB-1:0];
    den   <= {abs_dd, 1'b0};
    // y denominator is -2D, so its sign is the opposite of D's
    side.neg_x     <= s3_nx[NXW-1] ^ s3_dd[DDW-1];
    side.neg_y     <= s3_ny[NXW-1] ^ ~s3_dd[DDW-1];
    side.clip_x    <= 1'b0;
    side.clip_y    <= 1'b0;
    side.in_circle <= (s3_det == '0) || (s3_det[DETW-1] != s3_dd[DDW-1]);
    side.corner    <= s3_corner;
    side.degen     <= (s3_dd == '0);
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcc_cell.sv
// -----------------------------------------------------------------------------
// tcc_cell
// One restoring-division cell: produces one quotient bit for x and for y.
// -----------------------------------------------------------------------------
`default_nettype none

module tcc_cell import tcc_pkg::*; #(
  parameter int DB = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [DB-1:0]        in_den,
  input  logic [DB-1:0]        in_rem_x,
  input  logic [QUOT_BITS-1:0] in_low_x,
  input  logic [QUOT_BITS-1:0] in_q_x,
  input  logic [DB-1:0]        in_rem_y,
  input  logic [QUOT_BITS-1:0] in_low_y,
  input  logic [QUOT_BITS-1:0] in_q_y,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [DB-1:0]        out_den,
  output logic [DB-1:0]        out_rem_x,
  output logic [QUOT_BITS-1:0] out_low_x,
  output logic [QUOT_BITS-1:0] out_q_x,
  output logic [DB-1:0]        out_rem_y,
  output logic [QUOT_BITS-1:0] out_low_y,
  output logic [QUOT_BITS-1:0] out_q_y,
  output side_t                out_side
);

  logic [DB:0] den_ext;
  logic [DB:0] trial_x, trial_y;
  logic [DB:0] diff_x, diff_y;
  logic        ge_x, ge_y;

  always_comb begin
    den_ext = {1'b0, in_den};
    trial_x = {in_rem_x, in_low_x[QUOT_BITS-1]};
    trial_y = {in_rem_y, in_low_y[QUOT_BITS-1]};
    ge_x    = (trial_x >= den_ext);
    ge_y    = (trial_y >= den_ext);
    diff_x  = ge_x ? trial_x - den_ext : trial_x;
    diff_y  = ge_y ? trial_y - den_ext : trial_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den   <= in_den;
    out_side  <= in_side;
    out_rem_x <= diff_x[DB-1:0];
    out_rem_y <= diff_y[DB-1:0];
    out_low_x <= {in_low_x[QUOT_BITS-2:0], 1'b0};
    out_low_y <= {in_low_y[QUOT_BITS-2:0], 1'b0};
    out_q_x   <= {in_q_x[QUOT_BITS-2:0], ge_x};
    out_q_y   <= {in_q_y[QUOT_BITS-2:0], ge_y};
  end

endmodule

`default_nettype wire

>>> hw/rtl/triangle_circumcircle_point_test.sv
// -----------------------------------------------------------------------------
// triangle_circumcircle_point_test
// Pipelined incircle test: circumcentre, inside flag, corner and degenerate
// flags for one triangle and query point per beat.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the corners and query point and raise start; the
//   beat is taken at the rising edge where start is high and busy is low.
//   busy is always low, so a new beat may be issued on every cycle.
//   Result channel: done is high for exactly one cycle with the result; the
//   receiver has no way to stall, so it must take every result as it comes.
//   From the accepting edge to done, a beat passes four front-end stages,
//   one divider entry stage, 32 division cells (one quotient bit each) and
//   the output register.
//   Throughput is one beat per cycle; the division chain sets the latency.
//   Reset clears all valid bits: beats in flight are dropped and no done
//   pulse appears until a new beat has passed through the pipe.
// -----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcircle_point_test import tcc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         done,
  output logic signed [31:0]           center_x,
  output logic signed [31:0]           center_y,
  output logic                         inside_res,
  output logic                         is_corner,
  output logic                         degenerate,
  output logic                         center_clipped
);

  localparam int NB      = 3*COORD_BITS + 3;
  localparam int DB      = 2*COORD_BITS + 4;
  localparam int LATENCY = QUOT_BITS + 6;

  assign busy = 1'b0;

  logic            f_valid;
  logic [NB-1:0]   f_mag_x, f_mag_y;
  logic [DB-1:0]   f_den;
  side_t           f_side;

  tcc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .c_x      (c_x),
    .c_y      (c_y),
    .query_x  (query_x),
    .query_y  (query_y),
    .out_valid(f_valid),
    .mag_x    (f_mag_x),
    .mag_y    (f_mag_y),
    .den      (f_den),
    .side     (f_side)
  );

  // divider entry: a high part at or above the divisor means quotient >= 2^32
  logic [NB-1:0] hi_x, hi_y;
  logic [NB-1:0] den_wide;
  side_t         entry_side;

  always_comb begin
    hi_x       = f_mag_x >> QUOT_BITS;
    hi_y       = f_mag_y >> QUOT_BITS;
    den_wide   = NB'(f_den);
    entry_side = f_side;
    entry_side.clip_x = (hi_x >= den_wide);
    entry_side.clip_y = (hi_y >= den_wide);
  end

  logic                 c_valid [0:QUOT_BITS];
  logic [DB-1:0]        c_den   [0:QUOT_BITS];
  logic [DB-1:0]        c_rem_x [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] c_low_x [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] c_q_x   [0:QUOT_BITS];
  logic [DB-1:0]        c_rem_y [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] c_low_y [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] c_q_y   [0:QUOT_BITS];
  side_t                c_side  [0:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else begin
      c_valid[0] <= f_valid;
    end
    c_den[0]   <= f_den;
    c_rem_x[0] <= hi_x[DB-1:0];
    c_rem_y[0] <= hi_y[DB-1:0];
    c_low_x[0] <= QUOT_BITS'({{QUOT_BITS{1'b0}}, f_mag_x});
    c_low_y[0] <= QUOT_BITS'({{QUOT_BITS{1'b0}}, f_mag_y});
    c_side[0]  <= entry_side;
  end

  assign c_q_x[0] = '0;
  assign c_q_y[0] = '0;

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
    tcc_cell #(.DB(DB)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_valid[g]),
      .in_den   (c_den[g]),
      .in_rem_x (c_rem_x[g]),
      .in_low_x (c_low_x[g]),
      .in_q_x   (c_q_x[g]),
      .in_rem_y (c_rem_y[g]),
      .in_low_y (c_low_y[g]),
      .in_q_y   (c_q_y[g]),
      .in_side  (c_side[g]),
      .out_valid(c_valid[g+1]),
      .out_den  (c_den[g+1]),
      .out_rem_x(c_rem_x[g+1]),
      .out_low_x(c_low_x[g+1]),
      .out_q_x  (c_q_x[g+1]),
      .out_rem_y(c_rem_y[g+1]),
      .out_low_y(c_low_y[g+1]),
      .out_q_y  (c_q_y[g+1]),
      .out_side (c_side[g+1])
    );
  end

  // sign, saturation and degenerate masking
  side_t                t_side;
  logic [QUOT_BITS-1:0] t_q_x, t_q_y;
  logic                 clip_x, clip_y;
  logic [QUOT_BITS-1:0] val_x, val_y;

  always_comb begin
    t_side = c_side[QUOT_BITS];
    t_q_x  = c_q_x[QUOT_BITS];
    t_q_y  = c_q_y[QUOT_BITS];
    clip_x = t_side.clip_x ||
             (t_side.neg_x ? (t_q_x > NEG_LIMIT) : (t_q_x > POS_LIMIT));
    clip_y = t_side.clip_y ||
             (t_side.neg_y ? (t_q_y > NEG_LIMIT) : (t_q_y > POS_LIMIT));
    if (clip_x) begin
      val_x = t_side.neg_x ? NEG_LIMIT : POS_LIMIT;
    end else begin
      val_x = t_side.neg_x ? -t_q_x : t_q_x;
    end
    if (clip_y) begin
      val_y = t_side.neg_y ? NEG_LIMIT : POS_LIMIT;
    end else begin
      val_y = t_side.neg_y ? -t_q_y : t_q_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_valid[QUOT_BITS];
    end
    center_x       <= t_side.degen ? '0 : $signed(val_x);
    center_y       <= t_side.degen ? '0 : $signed(val_y);
    inside_res     <= ~t_side.degen & t_side.in_circle;
    center_clipped <= ~t_side.degen & (clip_x | clip_y);
    is_corner      <= t_side.corner;
    degenerate     <= t_side.degen;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("accepted beat did not complete after fixed latency");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      (center_x == 0 && center_y == 0 && !inside_res && !center_clipped))
    else $error("degenerate result carries non-zero fields");

  a_clip_value : assert property (@(posedge clk) disable iff (rst)
    (done && center_clipped) |->
      ($unsigned(center_x) == POS_LIMIT || $unsigned(center_x) == NEG_LIMIT ||
       $unsigned(center_y) == POS_LIMIT || $unsigned(center_y) == NEG_LIMIT))
    else $error("clipped result without a saturated coordinate");

endmodule

`default_nettype wire
